// ===== hw/rtl/wqn_pkg.sv =====
package wqn_pkg;

  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned STATUS_BITS = 2;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ZERO_DIV = 2'd1,
    STATUS_RANGE    = 2'd2
  } status_e;

  typedef struct packed {
    logic neg;
    logic round_up;
    logic zero_div;
  } flags_t;

endpackage

// ===== hw/rtl/wqn_intf.sv =====
interface wqn_weight_if;
  logic                                valid;
  logic                                ready;
  logic signed [wqn_pkg::WORD_BITS-1:0] raw_weight;

  modport source (output valid, output raw_weight, input ready);
  modport sink   (input valid, input raw_weight, output ready);
endinterface

interface wqn_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [wqn_pkg::WORD_BITS-1:0]   quantized_weight;
  logic        [wqn_pkg::STATUS_BITS-1:0] status;

  modport source (output valid, output quantized_weight, output status, input ready);
  modport sink   (input valid, input quantized_weight, input status, output ready);
endinterface

// ===== hw/rtl/wqn_div_cell.sv =====
module wqn_div_cell #(
  parameter int unsigned WB      = 32,
  parameter int unsigned BIT_IDX = 31
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [wqn_pkg::WORD_BITS-1:0] div_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [WB-1:0]                 mag_i,
  input  logic [wqn_pkg::WORD_BITS-1:0] rem_i,
  input  logic                          neg_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [WB-1:0]                 mag_o,
  output logic [wqn_pkg::WORD_BITS-1:0] rem_o,
  output logic                          neg_o
);

  logic                          valid_q;
  logic [WB-1:0]                 mag_q;
  logic [wqn_pkg::WORD_BITS-1:0] rem_q, rem_d;
  logic                          neg_q;
  logic [wqn_pkg::WORD_BITS:0]   trial;
  logic [wqn_pkg::WORD_BITS:0]   diff;
  logic                          fits;

  assign ready_o = !valid_q || ready_i;

  // one restoring step: bring down the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_i, mag_i[BIT_IDX]};
    diff  = trial - {1'b0, div_i};
    fits  = trial >= {1'b0, div_i};
    rem_d = fits ? diff[wqn_pkg::WORD_BITS-1:0] : trial[wqn_pkg::WORD_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      mag_q <= mag_i;
      rem_q <= rem_d;
      neg_q <= neg_i;
    end
  end

  assign valid_o = valid_q;
  assign mag_o   = mag_q;
  assign rem_o   = rem_q;
  assign neg_o   = neg_q;

endmodule

// ===== hw/rtl/wqn_round_cell.sv =====
module wqn_round_cell #(
  parameter int unsigned WB = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [wqn_pkg::WORD_BITS-1:0] div_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [WB-1:0]                 mag_i,
  input  logic [wqn_pkg::WORD_BITS-1:0] rem_i,
  input  logic                          neg_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [WB-1:0]                 base_o,
  output wqn_pkg::flags_t               flags_o
);

  logic            valid_q;
  logic [WB-1:0]   base_q, base_d;
  wqn_pkg::flags_t flags_q, flags_d;

  assign ready_o = !valid_q || ready_i;

  // floor multiple is the magnitude minus the remainder; round outward at half or more
  always_comb begin
    base_d           = mag_i - rem_i[WB-1:0];
    flags_d.neg      = neg_i;
    flags_d.round_up = (rem_i != '0) && ({rem_i, 1'b0} >= {1'b0, div_i});
    flags_d.zero_div = (div_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      base_q  <= base_d;
      flags_q <= flags_d;
    end
  end

  assign valid_o = valid_q;
  assign base_o  = base_q;
  assign flags_o = flags_q;

endmodule

// ===== hw/rtl/wqn_out_stage.sv =====
module wqn_out_stage #(
  parameter int unsigned WB = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [wqn_pkg::WORD_BITS-1:0] div_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [WB-1:0]                 base_i,
  input  wqn_pkg::flags_t               flags_i,
  wqn_result_if.source                  result_o
);

  localparam int unsigned PW = wqn_pkg::WORD_BITS + 1;
  localparam logic [PW-1:0] SIGN_LIM = PW'(1) << (WB - 1);

  logic                           valid_q;
  logic [wqn_pkg::WORD_BITS-1:0]  value_q, value_d;
  wqn_pkg::status_e               status_q, status_d;
  logic [PW-1:0]                  prod;
  logic [PW-1:0]                  prod_neg;
  logic                           over;

  assign ready_o = !valid_q || result_o.ready;

  always_comb begin
    prod     = PW'(base_i) + (flags_i.round_up ? {1'b0, div_i} : '0);
    prod_neg = '0 - prod;
    over     = prod > (flags_i.neg ? SIGN_LIM : SIGN_LIM - PW'(1));
    if (flags_i.zero_div) begin
      status_d = wqn_pkg::STATUS_ZERO_DIV;
      value_d  = '0;
    end else if (over) begin
      status_d = wqn_pkg::STATUS_RANGE;
      value_d  = '0;
    end else begin
      status_d = wqn_pkg::STATUS_OK;
      value_d  = flags_i.neg ? prod_neg[wqn_pkg::WORD_BITS-1:0]
                             : prod[wqn_pkg::WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  assign result_o.valid            = valid_q;
  assign result_o.quantized_weight = value_q;
  assign result_o.status           = status_q;

endmodule

// ===== hw/rtl/weight_quantize_nearest_unit.sv =====
// Snaps each signed weight word to the nearest multiple of the scale division,
// rounding half away from zero.
// Channels: weight_i (sink) carries raw_weight; result_o (source) carries
// quantized_weight and status (ok, zero division, out of range). Both use
// valid/ready; a word moves on a clock edge with both high.
// Configuration: cfg_we_i writes cfg_wdata_i into the scale division; write
// only while no word is in flight.
// Pipeline: one restoring divider cell per magnitude bit, one rounding cell and
// one output register.
// Throughput: one word per cycle unless stalled; every cell has its own valid
// bit and takes a new word whenever it is empty or its neighbor takes its word.
// Stall: a held result backs up cell by cell; empty cells keep filling, and
// weight_i.ready drops only once the first cell is full and blocked.
// Reset: all cells empty, scale division set to 1.
module weight_quantize_nearest_unit #(
  parameter int unsigned WEIGHT_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wqn_pkg::WORD_BITS-1:0] cfg_wdata_i,
  wqn_weight_if.sink                    weight_i,
  wqn_result_if.source                  result_o
);

  localparam int unsigned WB = WEIGHT_BITS;

  logic [wqn_pkg::WORD_BITS-1:0] scale_division_q;

  logic                          vld [WB+1];
  logic                          rdy [WB+1];
  logic [WB-1:0]                 mag [WB+1];
  logic [wqn_pkg::WORD_BITS-1:0] rem [WB+1];
  logic                          neg [WB+1];

  logic [WB-1:0]                 x_in;
  logic                          rnd_valid;
  logic                          out_ready;
  logic [WB-1:0]                 rnd_base;
  wqn_pkg::flags_t               rnd_flags;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_division_q <= wqn_pkg::WORD_BITS'(1);
    end else if (cfg_we_i) begin
      scale_division_q <= cfg_wdata_i;
    end
  end

  // take magnitude and sign of the low weight bits
  assign x_in           = weight_i.raw_weight[WB-1:0];
  assign vld[0]         = weight_i.valid;
  assign neg[0]         = x_in[WB-1];
  assign mag[0]         = x_in[WB-1] ? ('0 - x_in) : x_in;
  assign rem[0]         = '0;
  assign weight_i.ready = rdy[0];

  for (genvar k = 0; k < WB; k++) begin : g_cell
    wqn_div_cell #(
      .WB      (WB),
      .BIT_IDX (WB - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .div_i   (scale_division_q),
      .valid_i (vld[k]),
      .ready_o (rdy[k]),
      .mag_i   (mag[k]),
      .rem_i   (rem[k]),
      .neg_i   (neg[k]),
      .valid_o (vld[k+1]),
      .ready_i (rdy[k+1]),
      .mag_o   (mag[k+1]),
      .rem_o   (rem[k+1]),
      .neg_o   (neg[k+1])
    );
  end

  wqn_round_cell #(
    .WB (WB)
  ) u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .div_i   (scale_division_q),
    .valid_i (vld[WB]),
    .ready_o (rdy[WB]),
    .mag_i   (mag[WB]),
    .rem_i   (rem[WB]),
    .neg_i   (neg[WB]),
    .valid_o (rnd_valid),
    .ready_i (out_ready),
    .base_o  (rnd_base),
    .flags_o (rnd_flags)
  );

  wqn_out_stage #(
    .WB (WB)
  ) u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .div_i    (scale_division_q),
    .valid_i  (rnd_valid),
    .ready_o  (out_ready),
    .base_i   (rnd_base),
    .flags_i  (rnd_flags),
    .result_o (result_o)
  );

endmodule

// ===== test/weight_quantize_nearest_unit_test.sv =====
module weight_quantize_nearest_unit_test;

  localparam int unsigned WEIGHT_BITS = 32;
  localparam int unsigned LATENCY = WEIGHT_BITS + 2;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LONG_HOLD = 300;
  localparam logic [wqn_pkg::WORD_BITS-1:0] W_MAX = 32'h7FFF_FFFF;
  localparam logic [wqn_pkg::WORD_BITS-1:0] W_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [wqn_pkg::WORD_BITS-1:0] value;
    wqn_pkg::status_e status;
  } quantized_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [wqn_pkg::WORD_BITS-1:0] cfg_wdata;

  wqn_weight_if weight_if ();
  wqn_result_if result_if ();

  weight_quantize_nearest_unit #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .weight_i   (weight_if),
    .result_o   (result_if)
  );

  logic [wqn_pkg::WORD_BITS-1:0] pending_weights[$];
  quantized_t quantized_queue[$];
  logic [wqn_pkg::WORD_BITS-1:0] division_model;
  int unsigned errors;
  int unsigned cycle_count;
  int unsigned send_gap;
  int unsigned recv_hold;
  bit quiet;
  bit long_hold_req;

  function automatic quantized_t quantize_weight(logic [wqn_pkg::WORD_BITS-1:0] raw,
                                                 logic [wqn_pkg::WORD_BITS-1:0] div);
    logic [63:0] wmask, sbit, x, mag, d, quo, rem, thr, prod, limit, signed_prod;
    logic neg;
    quantized_t res;
    wmask = (64'd1 << WEIGHT_BITS) - 64'd1;
    sbit = 64'd1 << (WEIGHT_BITS - 1);
    x = {32'd0, raw} & wmask;
    neg = (x & sbit) != 64'd0;
    mag = neg ? (wmask - x + 64'd1) : x;
    d = {32'd0, div};
    res.value = '0;
    if (d == 64'd0) begin
      res.status = wqn_pkg::STATUS_ZERO_DIV;
    end else begin
      quo = mag / d;
      rem = mag % d;
      thr = (d / 64'd2) + (d % 64'd2);
      if (rem != 64'd0 && rem >= thr) begin
        quo = quo + 64'd1;
      end
      prod = quo * d;
      limit = neg ? sbit : (sbit - 64'd1);
      if (prod > limit) begin
        res.status = wqn_pkg::STATUS_RANGE;
      end else begin
        signed_prod = neg ? (64'd0 - prod) : prod;
        res.status = wqn_pkg::STATUS_OK;
        res.value = signed_prod[wqn_pkg::WORD_BITS-1:0];
      end
    end
    return res;
  endfunction

  function automatic logic [wqn_pkg::WORD_BITS-1:0] random_weight(
    logic [wqn_pkg::WORD_BITS-1:0] d
  );
    longint t;
    case ($urandom_range(0, 3))
      0: begin
        t = longint'($urandom);
      end
      1: begin
        t = longint'($urandom_range(0, 200)) - 100;
      end
      2: begin
        // land on either side of the rounding threshold
        t = longint'($urandom_range(0, 1000)) * longint'(d) + longint'(d / 2)
            + longint'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1) == 1) begin
          t = -t;
        end
      end
      default: begin
        if ($urandom_range(0, 1) == 1) begin
          t = longint'(W_MAX) - longint'($urandom_range(0, 3));
        end else begin
          t = -longint'(W_MIN) + longint'($urandom_range(0, 3));
        end
      end
    endcase
    return t[wqn_pkg::WORD_BITS-1:0];
  endfunction

  task automatic settle();
    do begin
      @(posedge clk_i);
    end while (pending_weights.size() != 0 || weight_if.valid || quantized_queue.size() != 0);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic program_division(logic [wqn_pkg::WORD_BITS-1:0] d);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    division_model = d;
  endtask

  initial begin
    clk_i = 1'b0;
  end

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("weight_quantize_nearest_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (weight_if.valid && weight_if.ready) begin
      quantized_queue.push_back(quantize_weight(weight_if.raw_weight, division_model));
    end
    if (!weight_if.valid || weight_if.ready) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        weight_if.valid <= 1'b0;
      end else if (pending_weights.size() > 0) begin
        weight_if.valid <= 1'b1;
        weight_if.raw_weight <= pending_weights.pop_front();
        if (!quiet && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 17);
        end
      end else begin
        weight_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    quantized_t oldest;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (quantized_queue.size() == 0) begin
        errors++;
        $display("%0t: expected nothing, got %h status %0d", $time,
                 result_if.quantized_weight, result_if.status);
      end else begin
        oldest = quantized_queue.pop_front();
        if (result_if.quantized_weight !== oldest.value) begin
          errors++;
          $display("%0t: quantized_weight expected %h, got %h", $time,
                   oldest.value, result_if.quantized_weight);
        end
        if (result_if.status !== oldest.status) begin
          errors++;
          $display("%0t: status expected %0d, got %0d", $time,
                   oldest.status, result_if.status);
        end
      end
    end
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      recv_hold = LONG_HOLD;
    end
    if (recv_hold > 0) begin
      recv_hold = recv_hold - 1;
      result_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      recv_hold = $urandom_range(0, 16);
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  initial begin
    logic [wqn_pkg::WORD_BITS-1:0] d;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    weight_if.valid = 1'b0;
    weight_if.raw_weight = '0;
    result_if.ready = 1'b0;
    division_model = 32'd1;
    errors = 0;
    cycle_count = 0;
    send_gap = 0;
    recv_hold = 0;
    quiet = 1'b0;
    long_hold_req = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    pending_weights = '{32'd0, 32'd1, 32'hFFFF_FFFF, W_MAX, W_MIN};
    program_division(32'd0);
    pending_weights = '{32'd5, W_MIN};
    program_division(32'd2);
    pending_weights = '{32'd1, 32'hFFFF_FFFF, 32'd3};
    program_division(32'd3);
    pending_weights = '{32'd2, 32'hFFFF_FFFE, 32'hFFFF_FFFF, W_MAX};
    program_division(32'd10);
    pending_weights = '{32'd5, 32'd4, 32'hFFFF_FFFB, 32'd20};
    program_division(32'h8000_0000);
    pending_weights = '{W_MIN, W_MAX};
    program_division(32'hFFFF_FFFF);
    pending_weights = '{W_MIN, W_MAX};
    program_division(32'd1000);
    pending_weights = '{W_MAX, W_MIN};

    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 6)
        0: d = $urandom_range(1, 16);
        1: d = $urandom_range(17, 4096);
        2: d = $urandom;
        3: d = $urandom_range(1, 100);
        4: begin
          case ($urandom_range(0, 3))
            0: d = 32'd0;
            1: d = 32'd1;
            2: d = 32'h8000_0000;
            default: d = 32'hFFFF_FFFF;
          endcase
        end
        default: d = $urandom_range(32'h0001_0000, 32'h0100_0000);
      endcase
      program_division(d);
      if (phase == 3) begin
        long_hold_req = 1'b1;
      end
      if (phase == 11) begin
        quiet = 1'b1;
      end
      repeat (150) pending_weights.push_back(random_weight(d));
    end

    settle();
    if (errors == 0) begin
      $display("weight_quantize_nearest_unit: match");
    end else begin
      $display("weight_quantize_nearest_unit: mismatch");
    end
    $finish;
  end

endmodule
